@@ src/lfps_pkg.sv @@
// Package for the line follower steering controller: register indexes, sensor
// pattern codes, junction classes and the 16-bit saturation helper.
// No dependencies.
package lfps_pkg;

    // Register indexes on the configuration port (byte address is 4 * index).
    localparam logic [1:0] REG_GAIN_PROP  = 2'd0;
    localparam logic [1:0] REG_GAIN_INTEG = 2'd1;
    localparam logic [1:0] REG_GAIN_DERIV = 2'd2;
    localparam logic [1:0] REG_BASE_SPEED = 2'd3;

    localparam logic [15:0] GAIN_PROP_RST  = 16'd2560;
    localparam logic [15:0] GAIN_INTEG_RST = 16'd128;
    localparam logic [15:0] GAIN_DERIV_RST = 16'd0;
    localparam logic [13:0] BASE_SPEED_RST = 14'd0;

    // Junction classes.
    localparam logic [1:0] JUNC_NONE     = 2'd0;
    localparam logic [1:0] JUNC_STRAIGHT = 2'd1;
    localparam logic [1:0] JUNC_RIGHT    = 2'd2;
    localparam logic [1:0] JUNC_LEFT     = 2'd3;

    // Sensor patterns, leftmost sensor in the most significant bit.
    localparam logic [4:0] PAT_CROSS      = 5'b11111;
    localparam logic [4:0] PAT_CROSS_NAR  = 5'b01110;
    localparam logic [4:0] PAT_RIGHT      = 5'b01111;
    localparam logic [4:0] PAT_RIGHT_NAR  = 5'b00110;
    localparam logic [4:0] PAT_LEFT       = 5'b11110;
    localparam logic [4:0] PAT_LEFT_NAR   = 5'b01100;
    localparam logic [4:0] PAT_OFF_P2     = 5'b00001;
    localparam logic [4:0] PAT_OFF_P1     = 5'b00111;
    localparam logic [4:0] PAT_OFF_ZERO   = 5'b00100;
    localparam logic [4:0] PAT_OFF_M1     = 5'b11100;
    localparam logic [4:0] PAT_OFF_M2     = 5'b11000;
    localparam logic [4:0] PAT_LOST       = 5'b00000;

    // Line offsets.
    localparam logic signed [2:0] OFF_P3 = 3'sd3;
    localparam logic signed [2:0] OFF_P2 = 3'sd2;
    localparam logic signed [2:0] OFF_P1 = 3'sd1;
    localparam logic signed [2:0] OFF_Z  = 3'sd0;
    localparam logic signed [2:0] OFF_M1 = -3'sd1;
    localparam logic signed [2:0] OFF_M2 = -3'sd2;
    localparam logic signed [2:0] OFF_M3 = -3'sd3;

    typedef logic signed [15:0] word16_t;

    // Clamp a 26-bit signed value to the 16-bit signed range.
    function automatic word16_t sat16(input logic signed [25:0] v);
        word16_t r;
        if (v[25:15] == {11{v[25]}}) begin
            r = v[15:0];
        end else if (v[25]) begin
            r = 16'sh8000;
        end else begin
            r = 16'sh7FFF;
        end
        return r;
    endfunction

endpackage

@@ src/line_follower_pid_steering.sv @@
// Line follower steering controller: sensor pattern decode, PID with
// saturating integral, and four saturated wheel targets.
// Depends on lfps_pkg.
//
//  channel   | ports                          | contents
//  ----------+--------------------------------+-----------------------------------
//  input     | s_tvalid s_tready s_tdata[7:0] | one sensor sample per item
//  result    | m_tvalid m_tready m_tdata[87:0]| wheels, correction, offset, class
//  config    | psel penable pwrite paddr ...  | gains and base speed, 4 registers
//
// One item is accepted per cycle while no stalled output holds the pipeline. The
// decode register is loaded at the edge that accepts an item; the multiplier
// stage, the correction sum and the wheel stage follow it, each registered.
// Reset is synchronous and clears the controller state and all valid flags;
// the registers return to their reset values.
// A stalled output holds the pipeline; empty stages still fill, so input is
// taken while a finished result waits.
module line_follower_pid_steering (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // sense_0 .. sense_4 in bits 0..4, bits 7:5 zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // wheel_a, wheel_b, wheel_c, wheel_d, correction,
                                   // line_offset[82:80], junction_kind[84:83], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers.
    logic [15:0]        gain_prop_reg;
    logic [15:0]        gain_integ_reg;
    logic [15:0]        gain_deriv_reg;
    logic signed [13:0] base_speed_reg;

    // Controller state.
    logic signed [2:0]  offset_reg, offset_next;
    logic signed [2:0]  prior_offset_reg;
    logic signed [15:0] integral_reg, integral_next;
    logic [1:0]         junction_reg, junction_next;
    logic signed [3:0]  deriv_next;

    // Stage 1: terms.
    logic               p1_valid_reg;
    logic signed [2:0]  p1_off_reg;
    logic signed [15:0] p1_int_reg;
    logic signed [3:0]  p1_d_reg;
    logic [1:0]         p1_junc_reg;

    // Stage 2: products.
    logic               p2_valid_reg;
    logic signed [19:0] p2_prod_p_reg, prod_p_next;
    logic signed [32:0] p2_prod_i_reg, prod_i_next;
    logic signed [20:0] p2_prod_d_reg, prod_d_next;
    logic signed [2:0]  p2_off_reg;
    logic [1:0]         p2_junc_reg;

    // Stage 3: correction.
    logic               p3_valid_reg;
    logic signed [15:0] p3_corr_reg, corr_next;
    logic signed [2:0]  p3_off_reg;
    logic [1:0]         p3_junc_reg;
    logic signed [33:0] acc_sum;

    // Output stage.
    logic               m_valid_reg;
    logic signed [15:0] wa_reg, wb_reg, wc_reg, wd_reg, corr_reg;
    logic signed [15:0] wa_next, wb_next, wc_next;
    logic signed [2:0]  off_out_reg;
    logic [1:0]         junc_out_reg;
    logic signed [17:0] plus_w, minus_w, neg_plus_w, neg_minus_w;

    logic [4:0] pat;
    logic       s_accept, cfg_write;
    logic       en1, en2, en3, en4;

    assign en4      = !m_valid_reg || m_tready;
    assign en3      = !p3_valid_reg || en4;
    assign en2      = !p2_valid_reg || en3;
    assign en1      = !p1_valid_reg || en2;
    assign s_tready = en1;
    assign s_accept = s_tvalid && s_tready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Leftmost sensor goes to the top of the pattern.
    assign pat = {s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[3], s_tdata[4]};

    always_comb begin
        logic signed [16:0] isum;
        offset_next   = offset_reg;
        junction_next = junction_reg;
        unique case (pat) inside
            lfps_pkg::PAT_CROSS, lfps_pkg::PAT_CROSS_NAR: junction_next = lfps_pkg::JUNC_STRAIGHT;
            lfps_pkg::PAT_RIGHT, lfps_pkg::PAT_RIGHT_NAR: junction_next = lfps_pkg::JUNC_RIGHT;
            lfps_pkg::PAT_LEFT, lfps_pkg::PAT_LEFT_NAR:   junction_next = lfps_pkg::JUNC_LEFT;
            lfps_pkg::PAT_OFF_P2:   offset_next = lfps_pkg::OFF_P2;
            lfps_pkg::PAT_OFF_P1:   offset_next = lfps_pkg::OFF_P1;
            lfps_pkg::PAT_OFF_ZERO: offset_next = lfps_pkg::OFF_Z;
            lfps_pkg::PAT_OFF_M1:   offset_next = lfps_pkg::OFF_M1;
            lfps_pkg::PAT_OFF_M2:   offset_next = lfps_pkg::OFF_M2;
            lfps_pkg::PAT_LOST: begin
                // Line lost: turn hard left only if the last offset was -2, else hard right.
                offset_next = (offset_reg == lfps_pkg::OFF_M2) ? lfps_pkg::OFF_M3
                                                                : lfps_pkg::OFF_P3;
            end
            default: ;
        endcase
        isum = {integral_reg[15], integral_reg} + {{14{offset_next[2]}}, offset_next};
        if (isum[16] != isum[15]) begin
            integral_next = isum[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            integral_next = isum[15:0];
        end
        deriv_next = {offset_next[2], offset_next} - {prior_offset_reg[2], prior_offset_reg};
    end

    // Gains are unsigned, so they enter the signed products with a zero on top.
    assign prod_p_next = $signed({4'b0, gain_prop_reg}) * {{17{p1_off_reg[2]}}, p1_off_reg};
    assign prod_i_next = $signed({17'b0, gain_integ_reg}) * {{17{p1_int_reg[15]}}, p1_int_reg};
    assign prod_d_next = $signed({5'b0, gain_deriv_reg}) * {{17{p1_d_reg[3]}}, p1_d_reg};

    // Dropping the low eight bits of the signed sum rounds toward minus infinity.
    assign acc_sum   = {{14{p2_prod_p_reg[19]}}, p2_prod_p_reg}
                     + {p2_prod_i_reg[32], p2_prod_i_reg}
                     + {{13{p2_prod_d_reg[20]}}, p2_prod_d_reg};
    assign corr_next = lfps_pkg::sat16(acc_sum[33:8]);

    assign plus_w      = {{4{base_speed_reg[13]}}, base_speed_reg}
                       + {{2{p3_corr_reg[15]}}, p3_corr_reg};
    assign minus_w     = {{4{base_speed_reg[13]}}, base_speed_reg}
                       - {{2{p3_corr_reg[15]}}, p3_corr_reg};
    assign neg_plus_w  = 18'sd0 - plus_w;
    assign neg_minus_w = 18'sd0 - minus_w;
    assign wa_next     = lfps_pkg::sat16({{8{neg_plus_w[17]}}, neg_plus_w});
    assign wb_next     = lfps_pkg::sat16({{8{neg_minus_w[17]}}, neg_minus_w});
    assign wc_next     = lfps_pkg::sat16({{8{plus_w[17]}}, plus_w});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg    <= lfps_pkg::GAIN_PROP_RST;
            gain_integ_reg   <= lfps_pkg::GAIN_INTEG_RST;
            gain_deriv_reg   <= lfps_pkg::GAIN_DERIV_RST;
            base_speed_reg   <= lfps_pkg::BASE_SPEED_RST;
            offset_reg       <= lfps_pkg::OFF_Z;
            prior_offset_reg <= lfps_pkg::OFF_Z;
            integral_reg     <= 16'sd0;
            junction_reg     <= lfps_pkg::JUNC_NONE;
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            p3_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_write) begin
                unique case (paddr[3:2])
                    lfps_pkg::REG_GAIN_PROP:  gain_prop_reg  <= pwdata[15:0];
                    lfps_pkg::REG_GAIN_INTEG: gain_integ_reg <= pwdata[15:0];
                    lfps_pkg::REG_GAIN_DERIV: gain_deriv_reg <= pwdata[15:0];
                    lfps_pkg::REG_BASE_SPEED: base_speed_reg <= pwdata[13:0];
                    default: ;
                endcase
            end
            if (s_accept) begin
                offset_reg       <= offset_next;
                prior_offset_reg <= offset_next;
                integral_reg     <= integral_next;
                junction_reg     <= junction_next;
            end
            if (en1) p1_valid_reg <= s_accept;
            if (en2) p2_valid_reg <= p1_valid_reg;
            if (en3) p3_valid_reg <= p2_valid_reg;
            if (en4) m_valid_reg  <= p3_valid_reg;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (en1) begin
            p1_off_reg  <= offset_next;
            p1_int_reg  <= integral_next;
            p1_d_reg    <= deriv_next;
            p1_junc_reg <= junction_next;
        end
        if (en2) begin
            p2_prod_p_reg <= prod_p_next;
            p2_prod_i_reg <= prod_i_next;
            p2_prod_d_reg <= prod_d_next;
            p2_off_reg    <= p1_off_reg;
            p2_junc_reg   <= p1_junc_reg;
        end
        if (en3) begin
            p3_corr_reg <= corr_next;
            p3_off_reg  <= p2_off_reg;
            p3_junc_reg <= p2_junc_reg;
        end
        if (en4) begin
            wa_reg       <= wa_next;
            wb_reg       <= wb_next;
            wc_reg       <= wc_next;
            wd_reg       <= wb_next;
            corr_reg     <= p3_corr_reg;
            off_out_reg  <= p3_off_reg;
            junc_out_reg <= p3_junc_reg;
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            lfps_pkg::REG_GAIN_PROP:  prdata = {16'b0, gain_prop_reg};
            lfps_pkg::REG_GAIN_INTEG: prdata = {16'b0, gain_integ_reg};
            lfps_pkg::REG_GAIN_DERIV: prdata = {16'b0, gain_deriv_reg};
            lfps_pkg::REG_BASE_SPEED: prdata = {{18{base_speed_reg[13]}}, base_speed_reg};
            default:                  prdata = 32'b0;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b0, junc_out_reg, off_out_reg, corr_reg,
                       wd_reg, wc_reg, wb_reg, wa_reg};

    // The offset never takes the one code outside -3 .. +3.
    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        offset_reg != 3'b100)
        else $error("line offset left its range");

    // A dark sample always ends with the offset at one of its extremes.
    a_lost_line: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && pat == lfps_pkg::PAT_LOST
        |=> offset_reg == lfps_pkg::OFF_P3 || offset_reg == lfps_pkg::OFF_M3)
        else $error("lost line did not saturate the offset");

    // Once a junction has been seen the class never returns to none.
    a_junction_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        junction_reg != lfps_pkg::JUNC_NONE |=> junction_reg != lfps_pkg::JUNC_NONE)
        else $error("junction class cleared without reset");

    // The derivative memory follows the offset of each accepted item.
    a_prior_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> prior_offset_reg == offset_reg)
        else $error("prior offset not updated");

endmodule

@@ tb/line_follower_pid_steering_tb.sv @@
// Testbench for line_follower_pid_steering: sensor samples are pushed through the stream
// ports and each result is checked against a steering predictor held in a scoreboard class.
// Depends on lfps_pkg and the line_follower_pid_steering RTL.
`timescale 1ns / 100ps

module line_follower_pid_steering_tb;

    typedef struct {
        logic signed [15:0] wheel_a;
        logic signed [15:0] wheel_b;
        logic signed [15:0] wheel_c;
        logic signed [15:0] wheel_d;
        logic signed [15:0] correction;
        logic signed [2:0]  line_offset;
        logic [1:0]         junction_kind;
    } steer_result_t;

    class steering_scoreboard;
        logic [15:0]        kp;
        logic [15:0]        ki;
        logic [15:0]        kd;
        logic signed [13:0] base;
        logic signed [2:0]  offset;
        logic signed [2:0]  prior;
        logic signed [15:0] integ;
        logic [1:0]         junction;
        steer_result_t      expected_q[$];
        int                 mismatches;
        int                 checked;

        function new();
            kp = lfps_pkg::GAIN_PROP_RST;
            ki = lfps_pkg::GAIN_INTEG_RST;
            kd = lfps_pkg::GAIN_DERIV_RST;
            base = lfps_pkg::BASE_SPEED_RST;
            offset = lfps_pkg::OFF_Z;
            prior = lfps_pkg::OFF_Z;
            integ = '0;
            junction = lfps_pkg::JUNC_NONE;
            mismatches = 0;
            checked = 0;
        endfunction

        function longint clamp16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                lfps_pkg::REG_GAIN_PROP:  kp = v[15:0];
                lfps_pkg::REG_GAIN_INTEG: ki = v[15:0];
                lfps_pkg::REG_GAIN_DERIV: kd = v[15:0];
                lfps_pkg::REG_BASE_SPEED: base = v[13:0];
                default: ;
            endcase
        endfunction

        // Pattern has the leftmost sensor in its top bit.
        function void note_sample(logic [4:0] pattern);
            longint        isum;
            longint        acc;
            longint        corr;
            longint        plus;
            longint        minus;
            longint        gp;
            longint        gi;
            longint        gd;
            steer_result_t r;
            case (pattern)
                lfps_pkg::PAT_CROSS, lfps_pkg::PAT_CROSS_NAR:
                    junction = lfps_pkg::JUNC_STRAIGHT;
                lfps_pkg::PAT_RIGHT, lfps_pkg::PAT_RIGHT_NAR:
                    junction = lfps_pkg::JUNC_RIGHT;
                lfps_pkg::PAT_LEFT, lfps_pkg::PAT_LEFT_NAR:
                    junction = lfps_pkg::JUNC_LEFT;
                lfps_pkg::PAT_OFF_P2:   offset = lfps_pkg::OFF_P2;
                lfps_pkg::PAT_OFF_P1:   offset = lfps_pkg::OFF_P1;
                lfps_pkg::PAT_OFF_ZERO: offset = lfps_pkg::OFF_Z;
                lfps_pkg::PAT_OFF_M1:   offset = lfps_pkg::OFF_M1;
                lfps_pkg::PAT_OFF_M2:   offset = lfps_pkg::OFF_M2;
                lfps_pkg::PAT_LOST:
                    offset = (offset == lfps_pkg::OFF_M2) ? lfps_pkg::OFF_M3
                                                          : lfps_pkg::OFF_P3;
                default: ;
            endcase
            isum = longint'(integ) + longint'(offset);
            integ = 16'(clamp16(isum));
            gp = kp;
            gi = ki;
            gd = kd;
            acc = gp * longint'(offset) + gi * longint'(integ)
                + gd * (longint'(offset) - longint'(prior));
            prior = offset;
            // Arithmetic shift of a signed sum rounds towards minus infinity.
            corr = clamp16(acc >>> 8);
            plus = longint'(base) + corr;
            minus = longint'(base) - corr;
            r.wheel_a = 16'(clamp16(-plus));
            r.wheel_b = 16'(clamp16(-minus));
            r.wheel_c = 16'(clamp16(plus));
            r.wheel_d = 16'(clamp16(-minus));
            r.correction = 16'(corr);
            r.line_offset = offset;
            r.junction_kind = junction;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %0d, got %0d", checked, name, want, got);
            end
        endfunction

        function void check_result(logic [87:0] data);
            steer_result_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected: %h", checked, data);
                checked++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("wheel_a", want.wheel_a, $signed(data[15:0]));
            compare_field("wheel_b", want.wheel_b, $signed(data[31:16]));
            compare_field("wheel_c", want.wheel_c, $signed(data[47:32]));
            compare_field("wheel_d", want.wheel_d, $signed(data[63:48]));
            compare_field("correction", want.correction, $signed(data[79:64]));
            compare_field("line_offset", want.line_offset, $signed(data[82:80]));
            compare_field("junction_kind", want.junction_kind, data[84:83]);
            checked++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    steering_scoreboard sb = new();
    bit                 no_gaps = 1'b0;
    int                 samples_sent = 0;
    int                 reg_writes = 0;
    logic [4:0]         known_patterns [12] = '{lfps_pkg::PAT_CROSS,
        lfps_pkg::PAT_CROSS_NAR, lfps_pkg::PAT_RIGHT, lfps_pkg::PAT_RIGHT_NAR,
        lfps_pkg::PAT_LEFT, lfps_pkg::PAT_LEFT_NAR, lfps_pkg::PAT_OFF_P2,
        lfps_pkg::PAT_OFF_P1, lfps_pkg::PAT_OFF_ZERO, lfps_pkg::PAT_OFF_M1,
        lfps_pkg::PAT_OFF_M2, lfps_pkg::PAT_LOST};
    logic [4:0]         directed_patterns [21] = '{lfps_pkg::PAT_OFF_ZERO,
        lfps_pkg::PAT_OFF_P1, lfps_pkg::PAT_OFF_P2, lfps_pkg::PAT_LOST,
        lfps_pkg::PAT_OFF_M1, lfps_pkg::PAT_OFF_M2, lfps_pkg::PAT_LOST,
        lfps_pkg::PAT_LOST, 5'b10101, lfps_pkg::PAT_CROSS, lfps_pkg::PAT_CROSS_NAR,
        5'b01010, lfps_pkg::PAT_RIGHT, lfps_pkg::PAT_RIGHT_NAR, lfps_pkg::PAT_OFF_M2,
        lfps_pkg::PAT_LEFT, lfps_pkg::PAT_LEFT_NAR, lfps_pkg::PAT_OFF_P2, 5'b10001,
        5'b11011, lfps_pkg::PAT_OFF_M1};

    line_follower_pid_steering DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // Sends one sensor sample; sense_0 goes to bit 0, i.e. the pattern's top bit.
    task automatic send_sample(logic [4:0] pattern);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, pattern[0], pattern[1], pattern[2], pattern[3], pattern[4]};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(pattern);
        samples_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, value);
        reg_writes++;
    endtask

    task automatic load_config(logic [15:0] p, logic [15:0] i, logic [15:0] d,
                               logic signed [13:0] b);
        wait_drain();
        write_reg(lfps_pkg::REG_GAIN_PROP, {16'd0, p});
        write_reg(lfps_pkg::REG_GAIN_INTEG, {16'd0, i});
        write_reg(lfps_pkg::REG_GAIN_DERIV, {16'd0, d});
        write_reg(lfps_pkg::REG_BASE_SPEED, {{18{b[13]}}, b});
    endtask

    // Mostly table patterns, with steep left edges followed by a lost line so that
    // the hard-left offset is reached, and some arbitrary sensor noise.
    task automatic random_samples(int count);
        int n;
        int roll;
        for (n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 29) == 0) no_gaps = ~no_gaps;
            if ($urandom_range(0, 49) == 0) wait_drain();
            if (roll < 12) begin
                send_sample(lfps_pkg::PAT_OFF_M2);
                send_sample(lfps_pkg::PAT_LOST);
            end else if (roll < 75) begin
                send_sample(known_patterns[$urandom_range(0, 11)]);
            end else begin
                send_sample(5'($urandom_range(0, 31)));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int n;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Table coverage at reset gains, junction persistence and the lost-line cases.
        for (n = 0; n < 21; n++) send_sample(directed_patterns[n]);

        load_config(16'd0, 16'd0, 16'd0, 14'sh2000);
        random_samples(60);
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 14'sd8191);
        random_samples(60);
        load_config(16'($urandom), 16'($urandom), 16'($urandom), 14'($urandom));
        random_samples(60);
        load_config(16'd256, 16'd1, 16'd768, 14'($urandom));
        random_samples(60);
        load_config(16'($urandom_range(0, 4095)), 16'($urandom_range(0, 255)),
                    16'($urandom), 14'($urandom));
        random_samples(60);

        // Full gains and top speed with no idle cycles on either side.
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 14'sd8191);
        no_gaps = 1'b1;
        send_sample(lfps_pkg::PAT_OFF_P1);
        for (n = 0; n < 12; n++) send_sample(lfps_pkg::PAT_LOST);
        for (n = 0; n < 12; n++) send_sample(lfps_pkg::PAT_OFF_M2);
        send_sample(lfps_pkg::PAT_LOST);
        send_sample(lfps_pkg::PAT_LOST);
        no_gaps = 1'b0;

        load_config(16'($urandom), 16'($urandom_range(0, 64)), 16'($urandom),
                    14'sh2000);
        random_samples(40);

        wait_drain();
        repeat (10) @(posedge aclk);
        $display("Sent %0d sensor samples and checked %0d results over %0d register writes,",
                 samples_sent, sb.checked, reg_writes);
        $display("including the extreme gain and speed settings and runs with no idle cycles.");
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
